FILE: hdl/cbsm_pkg.sv
// Shared types and constants for the cartridge bank-switch mapper.
package cbsm_pkg;

  localparam int ADDR_W     = 13;
  localparam int BUS_ADDR_W = 16;
  localparam int DATA_W     = 8;
  localparam int BANK_W     = 6;
  localparam int CNT_W      = 7;
  localparam int SEG_W      = 2;
  localparam int SEGS       = 4;
  localparam int OFFSET_W   = 10;
  localparam int RAM_OFF_W  = 9;
  localparam int BANKS      = 2 ** BANK_W;

  // Bits of the bank wrap resolved in each cycle of the remainder unit.
  localparam int MOD_STEP_BITS = 3;
  localparam int MOD_STEPS     = BANK_W / MOD_STEP_BITS;
  localparam int MOD_CNT_W     = (MOD_STEPS > 1) ? $clog2(MOD_STEPS) : 1;

  // Hotspot addresses, compared against the 13-bit bus address.
  localparam logic [ADDR_W-1:0] CTRL_RAM_ADDR = 13'h003E;
  localparam logic [ADDR_W-1:0] CTRL_ROM_ADDR = 13'h003F;

  localparam logic [CNT_W-1:0] ROM_BANK_COUNT_RESET = 7'd64;

  localparam logic MODE_READ  = 1'b0;
  localparam logic MODE_WRITE = 1'b1;

  typedef struct packed {
    logic              start;
    logic [BANK_W-1:0] dividend;
    logic [CNT_W-1:0]  divisor;
  } mod_req_t;

endpackage

FILE: hdl/cartridge_bank_switch_mapper_top.sv
// Top level of the cartridge bank-switch mapper: bus decode, segment table and cartridge RAM.
//
//   Channel  Direction  Handshake           Payload
//   in       to block   in_valid/in_stall   mode, address, data
//   out      from block out_valid/out_stall data_out, rom_fetch, rom_address
//   cfg      to block   cfg_write           cfg_data (ROM bank count)
//
// A pass-through access, a hotspot write or a RAM store goes from IDLE through FINISH to the
// output register; a RAM read passes through RAMRD first for the registered read of the RAM,
// and a ROM fetch waits in MOD for the remainder unit, which a zero bank count skips.
// One access is in flight at a time; the next transfer in is taken while a result waits.
// After reset a clearing pass writes zero to every RAM byte, with in_stall
// held high; bank count writes are taken during it.
// A stalled result holds the finished access in the FINISH state, and in_stall stays high.
module cartridge_bank_switch_mapper_top #(
  parameter int RAM_BYTES = 32768
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              mode,
  input  logic [cbsm_pkg::BUS_ADDR_W-1:0]   address,
  input  logic [cbsm_pkg::DATA_W-1:0]       data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [cbsm_pkg::DATA_W-1:0]       data_out,
  output logic                              rom_fetch,
  output logic [cbsm_pkg::BUS_ADDR_W-1:0]   rom_address,
  input  logic                              cfg_write,
  input  logic [cbsm_pkg::CNT_W-1:0]        cfg_data
);

  localparam int RAM_AW = $clog2(RAM_BYTES);

  // Sequencer states.
  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_RAMRD  = 3'd2;
  localparam logic [2:0] S_MOD    = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0]                    state;
  logic [RAM_AW-1:0]             clr_addr;
  logic [cbsm_pkg::CNT_W-1:0]    rom_bank_count;
  logic                          seg_ram  [cbsm_pkg::SEGS];
  logic [cbsm_pkg::BANK_W-1:0]   seg_bank [cbsm_pkg::SEGS];

  // Finished result waiting for the output register.
  logic [cbsm_pkg::DATA_W-1:0]     res_data;
  logic                            res_fetch;
  logic [cbsm_pkg::BUS_ADDR_W-1:0] res_addr;

  // Decode of the access on the input channel.
  logic [cbsm_pkg::ADDR_W-1:0]   addr13;
  logic [cbsm_pkg::SEG_W-1:0]    seg_sel;
  logic [cbsm_pkg::SEG_W-1:0]    ctrl_seg;
  logic [cbsm_pkg::OFFSET_W-1:0] offset;
  logic [cbsm_pkg::BANK_W-1:0]   cur_bank;
  logic                          cur_ram;
  logic                          accept;
  logic                          is_ctrl;
  logic                          in_window;
  logic                          do_fetch;
  logic                          do_store;
  logic                          do_load;
  logic                          out_free;

  // RAM index: bank * 512 + low offset, wrapped by the RAM size.
  logic [RAM_AW-1:0] bank_base [cbsm_pkg::BANKS];
  logic [RAM_AW:0]   ram_sum;
  logic [RAM_AW-1:0] ram_idx;

  logic [RAM_AW-1:0]           ram_addr;
  logic                        ram_we;
  logic [cbsm_pkg::DATA_W-1:0] ram_wdata;
  logic [cbsm_pkg::DATA_W-1:0] ram_rdata;

  cbsm_pkg::mod_req_t          mod_req;
  logic                        mod_done;
  logic [cbsm_pkg::BANK_W-1:0] mod_rem;

  // Each bank's base offset in the RAM is fixed by the RAM size, so it is a constant table.
  for (genvar b = 0; b < cbsm_pkg::BANKS; b++) begin : g_bank_base
    localparam int unsigned BASE = (b * 512) % RAM_BYTES;
    assign bank_base[b] = RAM_AW'(BASE);
  end

  assign addr13    = address[cbsm_pkg::ADDR_W-1:0];
  assign seg_sel   = addr13[11:10];
  assign offset    = addr13[cbsm_pkg::OFFSET_W-1:0];
  assign ctrl_seg  = data[7:6];
  assign cur_bank  = seg_bank[seg_sel];
  assign cur_ram   = seg_ram[seg_sel];
  assign accept    = in_valid && !in_stall;
  assign is_ctrl   = (mode == cbsm_pkg::MODE_WRITE) &&
                     ((addr13 == cbsm_pkg::CTRL_RAM_ADDR) ||
                      (addr13 == cbsm_pkg::CTRL_ROM_ADDR));
  assign in_window = !is_ctrl && addr13[12];

  // A ROM-mode read is the only access served by external ROM.
  assign do_fetch  = in_window && !cur_ram && (mode == cbsm_pkg::MODE_READ);
  // The upper half of a RAM-mode segment stores the bus byte, on reads as well.
  assign do_store  = in_window && cur_ram && offset[9];
  assign do_load   = in_window && cur_ram && !offset[9] && (mode == cbsm_pkg::MODE_READ);

  assign out_free  = !out_valid || !out_stall;
  assign in_stall  = (state != S_IDLE);

  // The partial sum stays below twice the RAM size, so one subtraction wraps it.
  assign ram_sum = {1'b0, bank_base[cur_bank]} +
                   (RAM_AW + 1)'(offset[cbsm_pkg::RAM_OFF_W-1:0]);
  assign ram_idx = (ram_sum >= (RAM_AW + 1)'(RAM_BYTES)) ?
                   RAM_AW'(ram_sum - (RAM_AW + 1)'(RAM_BYTES)) : ram_sum[RAM_AW-1:0];

  // The clearing pass owns the RAM port until it has swept every byte.
  always_comb begin
    if (state == S_CLEAR) begin
      ram_addr  = clr_addr;
      ram_we    = 1'b1;
      ram_wdata = '0;
    end else begin
      ram_addr  = ram_idx;
      ram_we    = accept && do_store;
      ram_wdata = data;
    end
  end

  cbsm_ram #(
    .WIDTH (cbsm_pkg::DATA_W),
    .DEPTH (RAM_BYTES)
  ) u_cart_ram (
    .clk   (clk),
    .addr  (ram_addr),
    .we    (ram_we),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // A zero bank count applies no wrap, so the remainder unit is skipped then.
  assign mod_req.start    = accept && do_fetch && (rom_bank_count != '0);
  assign mod_req.dividend = cur_bank;
  assign mod_req.divisor  = rom_bank_count;

  cbsm_bank_mod u_bank_mod (
    .clk       (clk),
    .rst       (rst),
    .req       (mod_req),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  // Control state: sequencer, clearing counter, segment table and bank count.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_CLEAR;
      clr_addr       <= '0;
      out_valid      <= 1'b0;
      rom_bank_count <= cbsm_pkg::ROM_BANK_COUNT_RESET;
      for (int s = 0; s < cbsm_pkg::SEGS; s++) begin
        seg_ram[s]  <= 1'b0;
        seg_bank[s] <= '0;
      end
    end else begin
      if (cfg_write) begin
        rom_bank_count <= cfg_data;
      end
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == RAM_AW'(RAM_BYTES - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            if (is_ctrl) begin
              seg_ram[ctrl_seg]  <= (addr13 == cbsm_pkg::CTRL_RAM_ADDR);
              seg_bank[ctrl_seg] <= data[cbsm_pkg::BANK_W-1:0];
            end
            if (do_load) begin
              state <= S_RAMRD;
            end else if (mod_req.start) begin
              state <= S_MOD;
            end else begin
              state <= S_FINISH;
            end
          end
        end
        S_RAMRD: begin
          state <= S_FINISH;
        end
        S_MOD: begin
          if (mod_done) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Result payload: built up while the access is in flight, then moved to the output.
  always_ff @(posedge clk) begin
    if (accept) begin
      res_data  <= data;
      res_fetch <= do_fetch;
      res_addr  <= do_fetch ? {cur_bank, offset} : '0;
    end
    if (state == S_RAMRD) begin
      res_data <= ram_rdata;
    end
    if ((state == S_MOD) && mod_done) begin
      res_addr[cbsm_pkg::BUS_ADDR_W-1:cbsm_pkg::OFFSET_W] <= mod_rem;
    end
    if ((state == S_FINISH) && out_free) begin
      data_out    <= res_data;
      rom_fetch   <= res_fetch;
      rom_address <= res_addr;
    end
  end

  // A new result only appears after a finished access has left the FINISH state.
  a_out_from_finish : assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_FINISH))
    else $error("result presented without a finished access");

  // The remainder unit only completes while the sequencer is waiting for it.
  a_mod_done_in_mod : assert property (@(posedge clk) disable iff (rst)
    mod_done |-> (state == S_MOD))
    else $error("bank wrap finished outside the wrap state");

  // The RAM is written only by the clearing pass or by a store on a transfer in.
  a_ram_we_owner : assert property (@(posedge clk) disable iff (rst)
    ram_we |-> ((state == S_CLEAR) || accept))
    else $error("RAM written with no owner");

  // Once a transfer in is taken, no further item is taken until it has finished.
  a_one_in_flight : assert property (@(posedge clk) disable iff (rst)
    accept |=> in_stall)
    else $error("second access taken while one is in flight");

endmodule

FILE: hdl/cbsm_ram.sv
// Generic single-port synchronous RAM with a registered read.
module cbsm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32768
) (
  input  logic                     clk,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic                     we,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

FILE: hdl/cbsm_bank_mod.sv
// Iterative remainder unit that wraps a bank number by the ROM bank count.
module cbsm_bank_mod (
  input  logic                      clk,
  input  logic                      rst,
  input  cbsm_pkg::mod_req_t        req,
  output logic                      done,
  output logic [cbsm_pkg::BANK_W-1:0] remainder
);

  logic                           busy;
  logic [cbsm_pkg::MOD_CNT_W-1:0] cnt;
  logic [cbsm_pkg::CNT_W-1:0]     rem;
  logic [cbsm_pkg::CNT_W-1:0]     divisor;
  logic [cbsm_pkg::BANK_W-1:0]    dividend;
  logic [cbsm_pkg::CNT_W-1:0]     rem_next;

  // Restoring division, a few dividend bits per cycle; only the remainder is kept.
  always_comb begin
    logic [cbsm_pkg::CNT_W:0]   trial;
    logic [cbsm_pkg::CNT_W-1:0] rem_w;
    rem_w = rem;
    trial = '0;
    for (int i = 0; i < cbsm_pkg::MOD_STEP_BITS; i++) begin
      trial = {rem_w, dividend[cbsm_pkg::BANK_W-1-i]};
      if (trial >= {1'b0, divisor}) begin
        trial = trial - {1'b0, divisor};
      end
      rem_w = trial[cbsm_pkg::CNT_W-1:0];
    end
    rem_next = rem_w;
  end

  assign done      = busy && (cnt == cbsm_pkg::MOD_CNT_W'(cbsm_pkg::MOD_STEPS - 1));
  assign remainder = rem_next[cbsm_pkg::BANK_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (done) begin
      busy <= 1'b0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem      <= '0;
      divisor  <= req.divisor;
      dividend <= req.dividend;
    end else if (busy) begin
      rem      <= rem_next;
      dividend <= {dividend[cbsm_pkg::BANK_W-1-cbsm_pkg::MOD_STEP_BITS:0],
                   cbsm_pkg::MOD_STEP_BITS'(0)};
    end
  end

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the cartridge bank-switch mapper: a directed table, then random bus traffic.
module tb_top;

  // The cartridge RAM size used by both the block and the behavioural copy below.
  localparam int RAM_BYTES       = 32768;
  localparam int RAM_AW          = $clog2(RAM_BYTES);
  // The random traffic runs in phases. Each phase starts with a new ROM bank count.
  localparam int RANDOM_PHASES   = 9;
  localparam int PHASE_ITEMS     = 150;
  // This is the length of the long receiver hold-off that lets the block back up onto its input.
  localparam int HOLD_OFF_CYCLES = 300;
  // These cycles follow the last result, so that a stray extra result would still be caught.
  localparam int DRAIN_CYCLES    = 16;
  localparam int MAX_WAIT        = 15;

  // Short names for the access kinds, so that the table rows stay readable.
  localparam logic RD = cbsm_pkg::MODE_READ;
  localparam logic WR = cbsm_pkg::MODE_WRITE;

  // One bus access, as offered on the input channel.
  typedef struct packed {
    logic                            mode;
    logic [cbsm_pkg::BUS_ADDR_W-1:0] address;
    logic [cbsm_pkg::DATA_W-1:0]     data;
  } bus_access_t;

  // What the block hands back for one access.
  typedef struct packed {
    logic [cbsm_pkg::DATA_W-1:0]     data_out;
    logic                            rom_fetch;
    logic [cbsm_pkg::BUS_ADDR_W-1:0] rom_address;
  } bus_reply_t;

  // A row of the directed table is either an access or a write of the bank count register.
  typedef enum logic {ROW_ACCESS, ROW_BANK_COUNT} row_kind_t;

  typedef struct packed {
    row_kind_t                       kind;
    logic                            mode;
    logic [cbsm_pkg::BUS_ADDR_W-1:0] address;
    logic [cbsm_pkg::DATA_W-1:0]     data;
    logic [cbsm_pkg::CNT_W-1:0]      count;
    logic                            known;      // The reply below is written out by hand.
    logic [cbsm_pkg::DATA_W-1:0]     exp_data;
    logic                            exp_fetch;
    logic [cbsm_pkg::BUS_ADDR_W-1:0] exp_rom_address;
  } dir_row_t;

  logic                            clk       = 1'b0;
  logic                            rst       = 1'b1;
  logic                            in_valid  = 1'b0;
  logic                            in_stall;
  logic                            mode      = cbsm_pkg::MODE_READ;
  logic [cbsm_pkg::BUS_ADDR_W-1:0] address   = '0;
  logic [cbsm_pkg::DATA_W-1:0]     data      = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic [cbsm_pkg::DATA_W-1:0]     data_out;
  logic                            rom_fetch;
  logic [cbsm_pkg::BUS_ADDR_W-1:0] rom_address;
  logic                            cfg_write = 1'b0;
  logic [cbsm_pkg::CNT_W-1:0]      cfg_data  = '0;

  // This is the testbench's own copy of the mapper state. It is updated as each access is taken.
  logic                            seg_is_ram [cbsm_pkg::SEGS];
  logic [cbsm_pkg::BANK_W-1:0]     seg_bank   [cbsm_pkg::SEGS];
  logic [cbsm_pkg::DATA_W-1:0]     cart_bytes [RAM_BYTES];
  logic [cbsm_pkg::CNT_W-1:0]      bank_count;

  // These are the replies still owed by the block, oldest first.
  bus_reply_t            owed_replies [$];
  int                    mismatches = 0;

  // These flags are shared by the two sides. They switch random waits on or off and ask for the
  // long hold-off.
  bit                    waits_on     = 1'b1;
  bit                    hold_off_req = 1'b0;

  // The directed table. The hand-written replies assume a block fresh out of reset with the bank
  // count at 64, except where a bank count row comes just before. The rest are left to the model.
  dir_row_t directed_rows [30] = '{
    // ROM fetches from segment 0 and segment 3 at bank 0, at the address extremes.
    '{ROW_ACCESS, RD, 16'h1000, 8'h5A, 7'd0,   1'b1, 8'h5A, 1'b1, 16'h0000},
    '{ROW_ACCESS, RD, 16'hFFFF, 8'hA5, 7'd0,   1'b1, 8'hA5, 1'b1, 16'h03FF},
    // Accesses below bit 12 pass the bus byte through. The hotspots do so on reads as well.
    '{ROW_ACCESS, RD, 16'h0000, 8'hFF, 7'd0,   1'b1, 8'hFF, 1'b0, 16'h0000},
    '{ROW_ACCESS, RD, 16'h003E, 8'h11, 7'd0,   1'b1, 8'h11, 1'b0, 16'h0000},
    '{ROW_ACCESS, RD, 16'hE03F, 8'h22, 7'd0,   1'b1, 8'h22, 1'b0, 16'h0000},
    // Segment 3 goes to ROM bank 63, then a fetch from it.
    '{ROW_ACCESS, WR, 16'h003F, 8'hFF, 7'd0,   1'b1, 8'hFF, 1'b0, 16'h0000},
    '{ROW_ACCESS, RD, 16'h1C05, 8'h00, 7'd0,   1'b1, 8'h00, 1'b1, 16'hFC05},
    // A mirrored hotspot puts segment 0 in RAM mode at bank 5. A read then finds cleared RAM.
    '{ROW_ACCESS, WR, 16'h203E, 8'h05, 7'd0,   1'b1, 8'h05, 1'b0, 16'h0000},
    '{ROW_ACCESS, RD, 16'h1000, 8'h33, 7'd0,   1'b1, 8'h00, 1'b0, 16'h0000},
    // An upper-half write stores, and the lower half reads it back.
    '{ROW_ACCESS, WR, 16'h1200, 8'h77, 7'd0,   1'b1, 8'h77, 1'b0, 16'h0000},
    '{ROW_ACCESS, RD, 16'h1000, 8'h00, 7'd0,   1'b0, 8'h00, 1'b0, 16'h0000},
    // A read of the upper half stores the bus byte too.
    '{ROW_ACCESS, RD, 16'h13FF, 8'h99, 7'd0,   1'b0, 8'h00, 1'b0, 16'h0000},
    '{ROW_ACCESS, RD, 16'h11FF, 8'h00, 7'd0,   1'b0, 8'h00, 1'b0, 16'h0000},
    // A lower-half write stores nothing.
    '{ROW_ACCESS, WR, 16'h1050, 8'hEE, 7'd0,   1'b0, 8'h00, 1'b0, 16'h0000},
    '{ROW_ACCESS, RD, 16'h1050, 8'h00, 7'd0,   1'b0, 8'h00, 1'b0, 16'h0000},
    // A write to a ROM-mode segment only passes the byte through.
    '{ROW_ACCESS, WR, 16'h1400, 8'h12, 7'd0,   1'b1, 8'h12, 1'b0, 16'h0000},
    '{ROW_ACCESS, WR, 16'h203F, 8'h7F, 7'd0,   1'b1, 8'h7F, 1'b0, 16'h0000},
    '{ROW_ACCESS, RD, 16'h1400, 8'h00, 7'd0,   1'b0, 8'h00, 1'b0, 16'h0000},
    // Segment 2 goes to RAM bank 63, which reaches the very top byte of the RAM.
    '{ROW_ACCESS, WR, 16'h003E, 8'hBF, 7'd0,   1'b1, 8'hBF, 1'b0, 16'h0000},
    '{ROW_ACCESS, WR, 16'h1BFF, 8'hAB, 7'd0,   1'b0, 8'h00, 1'b0, 16'h0000},
    '{ROW_ACCESS, RD, 16'h19FF, 8'h00, 7'd0,   1'b0, 8'h00, 1'b0, 16'h0000},
    '{ROW_ACCESS, WR, 16'h0FFF, 8'h42, 7'd0,   1'b1, 8'h42, 1'b0, 16'h0000},
    // A zero bank count applies no wrap at all.
    '{ROW_BANK_COUNT, RD, 16'h0000, 8'h00, 7'd0,   1'b0, 8'h00, 1'b0, 16'h0000},
    '{ROW_ACCESS,     RD, 16'h1C00, 8'h00, 7'd0,   1'b1, 8'h00, 1'b1, 16'hFC00},
    // A single bank folds every bank onto bank 0.
    '{ROW_BANK_COUNT, RD, 16'h0000, 8'h00, 7'd1,   1'b0, 8'h00, 1'b0, 16'h0000},
    '{ROW_ACCESS,     RD, 16'h1FFF, 8'h00, 7'd0,   1'b1, 8'h00, 1'b1, 16'h03FF},
    // A count above 64 leaves the bank as it is, and a smaller count wraps it.
    '{ROW_BANK_COUNT, RD, 16'h0000, 8'h00, 7'd127, 1'b0, 8'h00, 1'b0, 16'h0000},
    '{ROW_ACCESS,     RD, 16'h1C00, 8'h00, 7'd0,   1'b0, 8'h00, 1'b0, 16'h0000},
    '{ROW_BANK_COUNT, RD, 16'h0000, 8'h00, 7'd10,  1'b0, 8'h00, 1'b0, 16'h0000},
    '{ROW_ACCESS,     RD, 16'h1C00, 8'h00, 7'd0,   1'b0, 8'h00, 1'b0, 16'h0000}
  };

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  cartridge_bank_switch_mapper_top #(
    .RAM_BYTES (RAM_BYTES)
  ) u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .mode        (mode),
    .address     (address),
    .data        (data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .data_out    (data_out),
    .rom_fetch   (rom_fetch),
    .rom_address (rom_address),
    .cfg_write   (cfg_write),
    .cfg_data    (cfg_data)
  );

  // Works out the reply to one access and updates the shadow state as the mapper would.
  function automatic bus_reply_t map_access(input bus_access_t acc);
    logic [cbsm_pkg::ADDR_W-1:0]   addr;
    logic [cbsm_pkg::SEG_W-1:0]    seg;
    logic [cbsm_pkg::OFFSET_W-1:0] offset;
    logic [cbsm_pkg::BANK_W-1:0]   bank;
    logic [RAM_AW-1:0]             ram_at;
    bus_reply_t                    reply;
    addr              = acc.address[cbsm_pkg::ADDR_W-1:0];
    reply.data_out    = acc.data;
    reply.rom_fetch   = 1'b0;
    reply.rom_address = '0;
    if (acc.mode == cbsm_pkg::MODE_WRITE &&
        (addr == cbsm_pkg::CTRL_RAM_ADDR || addr == cbsm_pkg::CTRL_ROM_ADDR)) begin
      // This is a hotspot write. The top two data bits pick the segment.
      seg             = acc.data[cbsm_pkg::DATA_W-1 -: cbsm_pkg::SEG_W];
      seg_is_ram[seg] = (addr == cbsm_pkg::CTRL_RAM_ADDR);
      seg_bank[seg]   = acc.data[cbsm_pkg::BANK_W-1:0];
    end else if (addr[12]) begin
      seg    = addr[11:10];
      offset = addr[cbsm_pkg::OFFSET_W-1:0];
      ram_at = RAM_AW'((int'(seg_bank[seg]) * 512 +
                        int'(offset[cbsm_pkg::RAM_OFF_W-1:0])) % RAM_BYTES);
      if (!seg_is_ram[seg]) begin
        if (acc.mode == cbsm_pkg::MODE_READ) begin
          bank = seg_bank[seg];
          if (bank_count != '0) begin
            bank = cbsm_pkg::BANK_W'(bank % bank_count);
          end
          reply.rom_fetch   = 1'b1;
          reply.rom_address = {bank, offset};
        end
      end else if (offset[cbsm_pkg::RAM_OFF_W]) begin
        // In the upper half the bus byte is stored, whatever the access kind.
        cart_bytes[ram_at] = acc.data;
      end else if (acc.mode == cbsm_pkg::MODE_READ) begin
        reply.data_out = cart_bytes[ram_at];
      end
    end
    return reply;
  endfunction

  // Offers one access after any idle gap, and waits for its transfer. On acceptance the reply is
  // recorded. It is the hand-written one where a table row gives one, and the model's otherwise.
  // The task returns in the step of the transfer. Valid is left high, so that the next call
  // either keeps it high or lowers it, with one assignment in that step.
  task automatic offer_access(input bus_access_t acc, input int unsigned gap,
                              input logic known, input bus_reply_t typed);
    bus_reply_t modelled;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    mode     <= acc.mode;
    address  <= acc.address;
    data     <= acc.data;
    do @(posedge clk); while (in_stall);
    modelled = map_access(acc);
    owed_replies.push_back(known ? typed : modelled);
  endtask

  // Changes the ROM bank count. This happens only once every owed reply is in, so the block is idle.
  task automatic set_bank_count(input logic [cbsm_pkg::CNT_W-1:0] value);
    in_valid <= 1'b0;
    while (owed_replies.size() != 0) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    cfg_write  <= 1'b0;
    bank_count  = value;
  endtask

  // With waits on, the receiver waits a random number of cycles before each result. On request
  // it holds off for a long stretch, so that the block fills up and stalls the sender.
  initial begin : receiver
    int unsigned wait_cycles;
    forever begin
      if (hold_off_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end else begin
        wait_cycles = waits_on ? $urandom_range(0, MAX_WAIT) : 0;
        if (wait_cycles != 0) begin
          out_stall <= 1'b1;
          repeat (wait_cycles) @(posedge clk);
        end
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Every result transfer is compared, field by field, with the oldest owed reply.
  always @(posedge clk) begin : reply_check
    bus_reply_t want;
    if (!rst && out_valid && !out_stall) begin
      if (owed_replies.size() == 0) begin
        $error("unexpected result: data_out %0h rom_fetch %0b rom_address %0h",
               data_out, rom_fetch, rom_address);
        mismatches++;
      end else begin
        want = owed_replies.pop_front();
        if (data_out !== want.data_out) begin
          $error("data_out: expected %0h, got %0h", want.data_out, data_out);
          mismatches++;
        end
        if (rom_fetch !== want.rom_fetch) begin
          $error("rom_fetch: expected %0b, got %0b", want.rom_fetch, rom_fetch);
          mismatches++;
        end
        if (rom_address !== want.rom_address) begin
          $error("rom_address: expected %0h, got %0h", want.rom_address, rom_address);
          mismatches++;
        end
      end
    end
  end

  initial begin : stimulus
    bus_access_t                acc;
    bus_reply_t                 typed;
    int unsigned                pick;
    logic [cbsm_pkg::CNT_W-1:0] count;

    // The shadow state starts as the block does after its clearing pass.
    for (int s = 0; s < cbsm_pkg::SEGS; s++) begin
      seg_is_ram[s] = 1'b0;
      seg_bank[s]   = '0;
    end
    foreach (cart_bytes[i]) cart_bytes[i] = '0;
    bank_count = cbsm_pkg::ROM_BANK_COUNT_RESET;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed part. The block holds off the first access until its RAM clear is done.
    foreach (directed_rows[r]) begin
      if (directed_rows[r].kind == ROW_BANK_COUNT) begin
        set_bank_count(directed_rows[r].count);
      end else begin
        acc   = '{directed_rows[r].mode, directed_rows[r].address, directed_rows[r].data};
        typed = '{directed_rows[r].exp_data, directed_rows[r].exp_fetch,
                  directed_rows[r].exp_rom_address};
        offer_access(acc, $urandom_range(0, MAX_WAIT), directed_rows[r].known, typed);
      end
    end

    // Random part. The extremes of the bank count and its reset value come first, then random counts.
    // Every third phase runs with no waits on either side, and two phases include the long hold-off.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0:       count = '0;
        1:       count = 7'd1;
        2:       count = 7'd127;
        3:       count = cbsm_pkg::ROM_BANK_COUNT_RESET;
        default: count = cbsm_pkg::CNT_W'($urandom_range(1, 127));
      endcase
      set_bank_count(count);
      waits_on     = (p % 3 != 1);
      hold_off_req = (p == 2 || p == 6);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick        = $urandom_range(0, 99);
        acc.mode    = 1'($urandom_range(0, 1));
        acc.address = cbsm_pkg::BUS_ADDR_W'($urandom_range(0, 16'hFFFF));
        acc.data    = cbsm_pkg::DATA_W'($urandom_range(0, 8'hFF));
        if (pick < 15) begin
          // These are hotspot writes, often mirrored. Banks are mostly low, so that RAM
          // contents are read back often.
          acc.mode = cbsm_pkg::MODE_WRITE;
          acc.address[cbsm_pkg::ADDR_W-1:0] =
            $urandom_range(0, 1) ? cbsm_pkg::CTRL_RAM_ADDR : cbsm_pkg::CTRL_ROM_ADDR;
          if ($urandom_range(0, 3) != 0) begin
            acc.data[cbsm_pkg::BANK_W-1:0] = cbsm_pkg::BANK_W'($urandom_range(0, 3));
          end
        end else if (pick < 85) begin
          // Segment accesses make up the bulk of the traffic.
          acc.address[12] = 1'b1;
        end else if (pick < 92) begin
          // These are reads of the hotspots, which must not switch anything.
          acc.mode = cbsm_pkg::MODE_READ;
          acc.address[cbsm_pkg::ADDR_W-1:0] =
            $urandom_range(0, 1) ? cbsm_pkg::CTRL_RAM_ADDR : cbsm_pkg::CTRL_ROM_ADDR;
        end
        // Anything left over is fully random noise.
        offer_access(acc, waits_on ? $urandom_range(0, MAX_WAIT) : 0, 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    while (owed_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // This watchdog allows several times the slowest correct run, RAM clear included.
  initial begin : watchdog
    #1000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

FILE: cartridge_bank_switch_mapper_top.f
hdl/cbsm_pkg.sv
hdl/cbsm_ram.sv
hdl/cbsm_bank_mod.sv
hdl/cartridge_bank_switch_mapper_top.sv
verif/tb_top.sv
